/* rtl/obbt_pkg.sv */
// ============================================================================
// Oriented box overlap test package
// Shared constants, the series accumulator type and the reciprocal table
// used by the sine and cosine lanes.
// ============================================================================
package obbt_pkg;

  localparam int TERMS = 18;
  localparam int STAGES_PER_TERM = 3;
  localparam int TRIG_LAT = TERMS * STAGES_PER_TERM + 1;
  localparam int QDEPTH = 2;
  localparam logic [30:0] PIHALF_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  typedef struct packed {
    logic [30:0]        x;
    logic [1:0]         quad;
    logic [30:0]        term;
    logic signed [33:0] s;
    logic signed [33:0] c;
  } trig_acc_t;

  function automatic logic [31:0] recip(input int k);
    logic [31:0] r;
    case (k)
      2:       r = 32'd2147483648;
      3:       r = 32'd1431655765;
      4:       r = 32'd1073741824;
      5:       r = 32'd858993459;
      6:       r = 32'd715827882;
      7:       r = 32'd613566756;
      8:       r = 32'd536870912;
      9:       r = 32'd477218588;
      10:      r = 32'd429496729;
      11:      r = 32'd390451572;
      12:      r = 32'd357913941;
      13:      r = 32'd330382099;
      14:      r = 32'd306783378;
      15:      r = 32'd286331153;
      16:      r = 32'd268435456;
      17:      r = 32'd252645135;
      18:      r = 32'd238609294;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/obbt_front.sv */
// ============================================================================
// Oriented box overlap test front end
// Captures an item, forms the center offset and turns each angle into a
// quadrant and a first-quadrant angle in radians, Q30.
// ============================================================================
module obbt_front #(
  parameter int CW = 32,
  parameter int AB = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 full,
  output logic                 push,
  input  logic signed [CW-1:0] a_center_x,
  input  logic signed [CW-1:0] a_center_y,
  input  logic [CW-2:0]        a_width,
  input  logic [CW-2:0]        a_height,
  input  logic [AB-1:0]        a_angle,
  input  logic signed [CW-1:0] b_center_x,
  input  logic signed [CW-1:0] b_center_y,
  input  logic [CW-2:0]        b_width,
  input  logic [CW-2:0]        b_height,
  input  logic [AB-1:0]        b_angle,
  output logic signed [CW:0]   dx,
  output logic signed [CW:0]   dy,
  output logic [CW-2:0]        wa,
  output logic [CW-2:0]        ha,
  output logic [CW-2:0]        wb,
  output logic [CW-2:0]        hb,
  output logic [30:0]          xa,
  output logic [30:0]          xb,
  output logic [1:0]           qa,
  output logic [1:0]           qb
);

  logic        valid;
  logic        valid_next;
  logic        load;
  logic [29:0] ta;
  logic [29:0] tb;
  logic [60:0] pa;
  logic [60:0] pb;

  assign busy = valid & full;
  assign push = valid & ~full;
  assign load = start & ~busy;

  assign ta = 30'(a_angle[AB-3:0]) << (32 - AB);
  assign tb = 30'(b_angle[AB-3:0]) << (32 - AB);
  assign pa = 61'(ta) * 61'(obbt_pkg::PIHALF_Q30);
  assign pb = 61'(tb) * 61'(obbt_pkg::PIHALF_Q30);

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (push) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dx <= (CW+1)'(b_center_x) - (CW+1)'(a_center_x);
      dy <= (CW+1)'(b_center_y) - (CW+1)'(a_center_y);
      wa <= a_width;
      ha <= a_height;
      wb <= b_width;
      hb <= b_height;
      xa <= pa[60:30];
      xb <= pb[60:30];
      qa <= a_angle[AB-1:AB-2];
      qb <= b_angle[AB-1:AB-2];
    end
  end

endmodule

/* rtl/obbt_queue.sv */
// ============================================================================
// Oriented box overlap test queue
// A short first-in first-out queue between the front end and the back end.
// ============================================================================
module obbt_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  localparam int PW = $clog2(obbt_pkg::QDEPTH);
  localparam int NW = $clog2(obbt_pkg::QDEPTH + 1);

  logic [W-1:0]  mem [obbt_pkg::QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] count;

  assign full  = (count == NW'(obbt_pkg::QDEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(obbt_pkg::QDEPTH)) else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count lost a push");
`endif

endmodule

/* rtl/obbt_trig.sv */
// ============================================================================
// Oriented box overlap test sine and cosine lane
// Sums the Taylor series of sine and cosine one term per three stages and
// maps the quadrant onto the rounded pair.
// ============================================================================
module obbt_trig #(
  parameter int F = 16
) (
  input  logic                clk,
  input  logic [30:0]         in_x,
  input  logic [1:0]          in_quad,
  output logic signed [F+1:0] cs,
  output logic signed [F+1:0] sn
);

  obbt_pkg::trig_acc_t acc [obbt_pkg::TERMS+1];

  assign acc[0] = {in_x, in_quad, obbt_pkg::ONE_Q30, 34'd0, 34'(obbt_pkg::ONE_Q30)};

  for (genvar gk = 0; gk < obbt_pkg::TERMS; gk++) begin : g_term
    localparam int K = gk + 1;
    localparam logic [31:0] RECIP = obbt_pkg::recip(K);

    obbt_pkg::trig_acc_t a1;
    obbt_pkg::trig_acc_t a2;
    obbt_pkg::trig_acc_t a3;
    logic [61:0]         prod;
    logic [31:0]         p2;
    logic [63:0]         qp;
    logic [31:0]         q0;
    logic [36:0]         rem;
    logic [31:0]         qc;

    always_ff @(posedge clk) begin
      a1   <= acc[gk];
      prod <= 62'(acc[gk].x) * 62'(acc[gk].term);
      a2   <= a1;
      p2   <= prod[61:30];
      qp   <= 64'(prod[61:30]) * 64'(RECIP);
    end

    always_comb begin
      q0  = qp[63:32];
      rem = 37'(p2) - 37'(q0) * 37'(K);
      if (K == 1) begin
        qc = p2;
      end else if (rem >= 37'(K)) begin
        qc = q0 + 32'd1;
      end else begin
        qc = q0;
      end
    end

    always_ff @(posedge clk) begin
      a3.x    <= a2.x;
      a3.quad <= a2.quad;
      a3.term <= qc[30:0];
      if ((K % 2) == 1) begin
        a3.c <= a2.c;
        if ((K % 4) == 1) begin
          a3.s <= a2.s + 34'(qc[30:0]);
        end else begin
          a3.s <= a2.s - 34'(qc[30:0]);
        end
      end else begin
        a3.s <= a2.s;
        if ((K % 4) == 0) begin
          a3.c <= a2.c + 34'(qc[30:0]);
        end else begin
          a3.c <= a2.c - 34'(qc[30:0]);
        end
      end
    end

    assign acc[gk+1] = a3;
  end

  logic [30:0]         vs;
  logic [30:0]         vc;
  logic [30:0]         rs;
  logic [30:0]         rc;
  logic signed [F+1:0] fs;
  logic signed [F+1:0] fc;

  always_comb begin
    if (acc[obbt_pkg::TERMS].s[33]) begin
      vs = '0;
    end else if (acc[obbt_pkg::TERMS].s > 34'(obbt_pkg::ONE_Q30)) begin
      vs = obbt_pkg::ONE_Q30;
    end else begin
      vs = acc[obbt_pkg::TERMS].s[30:0];
    end
    if (acc[obbt_pkg::TERMS].c[33]) begin
      vc = '0;
    end else if (acc[obbt_pkg::TERMS].c > 34'(obbt_pkg::ONE_Q30)) begin
      vc = obbt_pkg::ONE_Q30;
    end else begin
      vc = acc[obbt_pkg::TERMS].c[30:0];
    end
    rs = vs + (31'd1 << (29 - F));
    rc = vc + (31'd1 << (29 - F));
    fs = (F+2)'(rs[30:30-F]);
    fc = (F+2)'(rc[30:30-F]);
  end

  always_ff @(posedge clk) begin
    case (acc[obbt_pkg::TERMS].quad)
      2'd0: begin
        cs <= fc;
        sn <= fs;
      end
      2'd1: begin
        cs <= -fs;
        sn <= fc;
      end
      2'd2: begin
        cs <= -fc;
        sn <= -fs;
      end
      default: begin
        cs <= fs;
        sn <= -fc;
      end
    endcase
  end

endmodule

/* rtl/obbt_sat.sv */
// ============================================================================
// Oriented box overlap test back end
// Runs both sine and cosine lanes, then projects the offset and both boxes
// onto the four box axes and checks each axis for separation.
// ============================================================================
module obbt_sat #(
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [CW:0] dx,
  input  logic signed [CW:0] dy,
  input  logic [CW-2:0]      wa,
  input  logic [CW-2:0]      ha,
  input  logic [CW-2:0]      wb,
  input  logic [CW-2:0]      hb,
  input  logic [30:0]        xa,
  input  logic [30:0]        xb,
  input  logic [1:0]         qa,
  input  logic [1:0]         qb,
  output logic               done,
  output logic               overlap
);

  localparam int LAT = obbt_pkg::TRIG_LAT;
  localparam int SW  = 2 * (CW + 1) + 4 * (CW - 1);
  localparam int DW  = 2 * F + 2;
  localparam int H   = DW / 2;
  localparam int RW  = CW + 2 * F + 3;
  localparam int LW  = RW + 1;

  logic signed [F+1:0] ca;
  logic signed [F+1:0] sa;
  logic signed [F+1:0] cb;
  logic signed [F+1:0] sb;

  obbt_trig #(.F(F)) u_trig_a (.clk(clk), .in_x(xa), .in_quad(qa), .cs(ca), .sn(sa));
  obbt_trig #(.F(F)) u_trig_b (.clk(clk), .in_x(xb), .in_quad(qb), .cs(cb), .sn(sb));

  logic [SW-1:0] side [LAT];
  logic [LAT-1:0] vdly;

  always_ff @(posedge clk) begin
    side[0] <= {dx, dy, wa, ha, wb, hb};
    for (int n = 1; n < LAT; n++) begin
      side[n] <= side[n-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vdly <= '0;
    end else begin
      vdly <= {vdly[LAT-2:0], in_valid};
    end
  end

  logic signed [CW:0]   sdx;
  logic signed [CW:0]   sdy;
  logic [CW-2:0]        sz0 [4];
  logic signed [F+1:0]  ux [4];
  logic signed [F+1:0]  uy [4];

  always_comb begin
    {sdx, sdy, sz0[0], sz0[1], sz0[2], sz0[3]} = side[LAT-1];
    ux[0] = ca;
    uy[0] = sa;
    ux[1] = -sa;
    uy[1] = ca;
    ux[2] = cb;
    uy[2] = sb;
    ux[3] = -sb;
    uy[3] = cb;
  end

  logic signed [2*F+4:0]  d1 [4][4];
  logic signed [CW+F+3:0] l1 [4];
  logic [CW-2:0]          sz1 [4];
  logic [DW-1:0]          d2 [4][4];
  logic [LW-1:0]          l2 [4];
  logic [CW-2:0]          sz2 [4];
  logic [CW-2+H:0]        plo [4][4];
  logic [CW-2+DW-H:0]     phi [4][4];
  logic [LW-1:0]          l3 [4];
  logic [RW-1:0]          rsum [4];
  logic [RW-1:0]          r4 [4];
  logic [LW-1:0]          l4 [4];
  logic [3:0]             sep;
  logic                   v1;
  logic                   v2;
  logic                   v3;
  logic                   v4;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rsum[i] = '0;
      for (int j = 0; j < 4; j++) begin
        rsum[i] = rsum[i] + RW'(plo[i][j]) + (RW'(phi[i][j]) << H);
      end
      sep[i] = ({1'b0, r4[i]} <= l4[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        d1[i][j]  <= ux[i] * ux[j] + uy[i] * uy[j];
        d2[i][j]  <= (d1[i][j] < 0) ? DW'(-d1[i][j]) : DW'(d1[i][j]);
        plo[i][j] <= (CW-1+H)'(sz2[j]) * (CW-1+H)'(d2[i][j][H-1:0]);
        phi[i][j] <= (CW-1+DW-H)'(sz2[j]) * (CW-1+DW-H)'(d2[i][j][DW-1:H]);
      end
      l1[i]  <= sdx * ux[i] + sdy * uy[i];
      l2[i]  <= ((l1[i] < 0) ? LW'(-l1[i]) : LW'(l1[i])) << (F + 1);
      l3[i]  <= l2[i];
      l4[i]  <= l3[i];
      r4[i]  <= rsum[i];
      sz1[i] <= sz0[i];
      sz2[i] <= sz1[i];
    end
    overlap <= ~(|sep);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= vdly[LAT-1];
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

endmodule

/* rtl/obb_overlap_test_unit.sv */
// ============================================================================
// Oriented box overlap test
// Separating axis test of two rotated boxes; one item in, one result out.
// ============================================================================
// Throughput: one item per cycle; the sine and cosine lanes and the projection
// stages are fully pipelined, so busy stays low in normal operation.
// Reset clears the valid bits and the queue; results in flight are dropped.
module obb_overlap_test_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int ANGLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] a_center_x,
  input  logic signed [COORD_WIDTH-1:0] a_center_y,
  input  logic [COORD_WIDTH-2:0]        a_width,
  input  logic [COORD_WIDTH-2:0]        a_height,
  input  logic [ANGLE_BITS-1:0]         a_angle,
  input  logic signed [COORD_WIDTH-1:0] b_center_x,
  input  logic signed [COORD_WIDTH-1:0] b_center_y,
  input  logic [COORD_WIDTH-2:0]        b_width,
  input  logic [COORD_WIDTH-2:0]        b_height,
  input  logic [ANGLE_BITS-1:0]         b_angle,
  output logic                          done,
  output logic                          overlap
);

  localparam int CW = COORD_WIDTH;
  localparam int QW = 2 * (CW + 1) + 4 * (CW - 1) + 2 * 31 + 2 * 2;

  logic               full;
  logic               empty;
  logic               push;
  logic signed [CW:0] f_dx;
  logic signed [CW:0] f_dy;
  logic [CW-2:0]      f_wa;
  logic [CW-2:0]      f_ha;
  logic [CW-2:0]      f_wb;
  logic [CW-2:0]      f_hb;
  logic [30:0]        f_xa;
  logic [30:0]        f_xb;
  logic [1:0]         f_qa;
  logic [1:0]         f_qb;
  logic [QW-1:0]      q_out;
  logic signed [CW:0] q_dx;
  logic signed [CW:0] q_dy;
  logic [CW-2:0]      q_wa;
  logic [CW-2:0]      q_ha;
  logic [CW-2:0]      q_wb;
  logic [CW-2:0]      q_hb;
  logic [30:0]        q_xa;
  logic [30:0]        q_xb;
  logic [1:0]         q_qa;
  logic [1:0]         q_qb;

  obbt_front #(.CW(CW), .AB(ANGLE_BITS)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .full(full), .push(push),
    .a_center_x(a_center_x), .a_center_y(a_center_y), .a_width(a_width),
    .a_height(a_height), .a_angle(a_angle), .b_center_x(b_center_x),
    .b_center_y(b_center_y), .b_width(b_width), .b_height(b_height),
    .b_angle(b_angle), .dx(f_dx), .dy(f_dy), .wa(f_wa), .ha(f_ha), .wb(f_wb),
    .hb(f_hb), .xa(f_xa), .xb(f_xb), .qa(f_qa), .qb(f_qb)
  );

  obbt_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst), .push(push),
    .din({f_dx, f_dy, f_wa, f_ha, f_wb, f_hb, f_xa, f_xb, f_qa, f_qb}),
    .pop(~empty), .dout(q_out), .full(full), .empty(empty)
  );

  assign {q_dx, q_dy, q_wa, q_ha, q_wb, q_hb, q_xa, q_xb, q_qa, q_qb} = q_out;

  obbt_sat #(.CW(CW), .F(FRAC_BITS)) u_sat (
    .clk(clk), .rst(rst), .in_valid(~empty), .dx(q_dx), .dy(q_dy), .wa(q_wa),
    .ha(q_ha), .wb(q_wb), .hb(q_hb), .xa(q_xa), .xb(q_xb), .qa(q_qa), .qb(q_qb),
    .done(done), .overlap(overlap)
  );

endmodule
